@@ hdl/shs_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

  // Depth of the command queue between front and back end.
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CountWidth = 61;
  localparam int unsigned LenWidth   = 64;

  // Operation codes of an input item.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Padding constants.
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] PAD_STOP   = LEN_OFFSET - 6'd1;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  // One queued command.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Initial hash value word i.
  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = 32'h6a09e667;
    endcase
    return h;
  endfunction

  // Round constant for round t.
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h428a2f98;
    endcase
    return k;
  endfunction

  // Round Sigma0 on working word a.
  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Round Sigma1 on working word e.
  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Schedule sigma0.
  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Schedule sigma1.
  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ hdl/shs_if.sv @@
// Valid/ready channel interfaces for the hasher's input and digest streams.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ hdl/shs_front.sv @@
// Front end: accepts input transfers into a short command queue for the back end.
module shs_front #(
  parameter int unsigned QUEUE_DEPTH = shs_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  shs_in_if.sink          in_ch,
  output logic            q_valid,
  output shs_pkg::item_t  q_item,
  input  logic            q_ready
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  shs_pkg::item_t  q_mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ch.ready = (cnt_r != CntFull);
  assign q_valid     = (cnt_r != '0);
  assign q_item      = q_mem[rd_ptr_r];

  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_valid && q_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{op: in_ch.op, data_byte: in_ch.data_byte};
    end
  end

endmodule

@@ hdl/shs_back.sv @@
// Back end: block buffer, padding sequencer, one-round-per-cycle compression, digest output.
module shs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  shs_pkg::item_t q_item,
  output logic           q_ready,
  shs_out_if.source      out_ch
);

  shs_pkg::state_t state_r, state_nxt;
  shs_pkg::state_t ret_r, ret_nxt;

  logic [5:0]                       fill_r, fill_nxt;
  logic [shs_pkg::CountWidth-1:0]   count_r, count_nxt;
  logic [shs_pkg::LenWidth-1:0]     len_r, len_nxt;
  logic                             pad_first_r, pad_first_nxt;
  logic [5:0]                       rnd_r, rnd_nxt;
  logic [2:0]                       widx_r, widx_nxt;
  logic [511:0]                     msg_r, msg_nxt;
  logic [7:0][31:0]                 v_r, v_nxt;
  logic [7:0][31:0]                 chain_r, chain_nxt;

  logic       push;
  logic [7:0] push_byte;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, ch, mj;

  // Schedule window taps: word 0 is the oldest
  assign w0  = msg_r[511:480];
  assign w1  = msg_r[479:448];
  assign w9  = msg_r[223:192];
  assign w14 = msg_r[63:32];
  assign w_new = w0 + shs_pkg::sml_sig0(w1) + w9 + shs_pkg::sml_sig1(w14);

  // One compression round
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + shs_pkg::big_sig1(v_r[4]) + ch + shs_pkg::round_k(rnd_r) + w0;
  assign t2 = shs_pkg::big_sig0(v_r[0]) + mj;

  // Drive the digest stream from the chaining registers
  assign out_ch.valid       = (state_r == shs_pkg::ST_EMIT);
  assign out_ch.digest_word = chain_r[widx_r];
  assign out_ch.word_index  = widx_r;
  assign out_ch.last_word   = (widx_r == shs_pkg::WORD_LAST);

  // Sequence filling, padding, rounds and output
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    pad_first_nxt = pad_first_r;
    rnd_nxt       = rnd_r;
    widx_nxt      = widx_r;
    msg_nxt       = msg_r;
    v_nxt         = v_r;
    chain_nxt     = chain_r;
    q_ready       = 1'b0;
    push          = 1'b0;
    push_byte     = '0;

    unique case (state_r)
      shs_pkg::ST_FILL: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.op == shs_pkg::OP_FINISH) begin
            len_nxt       = {count_r, 3'b000};
            pad_first_nxt = 1'b1;
            state_nxt     = shs_pkg::ST_PAD;
          end else begin
            push      = 1'b1;
            push_byte = q_item.data_byte;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      shs_pkg::ST_PAD: begin
        push          = 1'b1;
        push_byte     = pad_first_r ? shs_pkg::PAD_BYTE : 8'h00;
        pad_first_nxt = 1'b0;
        if (fill_r == shs_pkg::PAD_STOP) begin
          state_nxt = shs_pkg::ST_LEN;
        end
      end
      shs_pkg::ST_LEN: begin
        push      = 1'b1;
        push_byte = len_r[shs_pkg::LenWidth-1 -: 8];
        len_nxt   = {len_r[shs_pkg::LenWidth-9:0], 8'h00};
      end
      shs_pkg::ST_ROUND: begin
        msg_nxt = {msg_r[479:0], w_new};
        v_nxt   = {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == shs_pkg::ROUND_LAST) begin
          state_nxt = shs_pkg::ST_FOLD;
        end
      end
      shs_pkg::ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        state_nxt = ret_r;
      end
      shs_pkg::ST_EMIT: begin
        if (out_ch.ready) begin
          widx_nxt = widx_r + 1'b1;
          if (widx_r == shs_pkg::WORD_LAST) begin
            for (int i = 0; i < 8; i++) begin
              chain_nxt[i] = shs_pkg::init_h(3'(i));
            end
            count_nxt = '0;
            fill_nxt  = '0;
            state_nxt = shs_pkg::ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = shs_pkg::ST_FILL;
      end
    endcase

    // Shift a byte into the block; start compression when the block is full
    if (push) begin
      msg_nxt  = {msg_r[503:0], push_byte};
      fill_nxt = fill_r + 1'b1;
      if (fill_r == shs_pkg::FILL_LAST) begin
        v_nxt     = chain_r;
        rnd_nxt   = '0;
        state_nxt = shs_pkg::ST_ROUND;
        ret_nxt   = (state_r == shs_pkg::ST_LEN) ? shs_pkg::ST_EMIT : state_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shs_pkg::ST_FILL;
      ret_r       <= shs_pkg::ST_FILL;
      fill_r      <= '0;
      count_r     <= '0;
      pad_first_r <= 1'b0;
      rnd_r       <= '0;
      widx_r      <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= shs_pkg::init_h(3'(i));
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      pad_first_r <= pad_first_nxt;
      rnd_r       <= rnd_nxt;
      widx_r      <= widx_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // Hold data path registers
  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
    v_r   <= v_nxt;
    len_r <= len_nxt;
  end

endmodule

@@ hdl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: command queue front end and compression back end.
//
// Usage:
//   in_ch carries one command per transfer: op = 0 appends data_byte to the
//   message, op = 1 finishes the message and requests its digest.
//   out_ch returns eight transfers per finish: digest_word, most significant
//   word first, word_index 0 to 7, last_word set on the eighth.
// Timing:
//   Commands enter a QUEUE_DEPTH-entry queue and leave it at one per cycle while
//   the back end is filling. Each 64th appended byte starts a compression of 64
//   rounds, one per cycle, then a fold into the chaining value; the queue stops
//   draining during the rounds and the fold.
//   A finish is taken, then the padding and length bytes (up to 72) are pushed
//   one by one, followed by one or two compressions, then the eight digest words.
// Reset:
//   rst_n is synchronous, active low; it empties the queue and loads the
//   initial hash values. After the last digest word the hasher reloads the
//   initial hash values by itself; commands already queued are kept.
// Stalls:
//   While out_ch.ready is low the current digest word is held; the queue
//   keeps taking commands until it is full, then in_ch.ready drops.
module sha256_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = shs_pkg::QueueDepth
) (
  input logic        clk,
  input logic        rst_n,
  shs_in_if.sink     in_ch,
  shs_out_if.source  out_ch
);

  logic           q_valid;
  logic           q_ready;
  shs_pkg::item_t q_item;

  shs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  shs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/sv/tb_sha256_stream_hasher.sv @@
// Self-checking testbench for sha256_stream_hasher: byte stream in, digest words out.
module tb_sha256_stream_hasher;

  // SHA-256 round constants.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial chaining value.
  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int unsigned MsgTarget = 470;
  localparam int unsigned TailCycles = 150;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Channel drive registers, known from time zero.
  logic       in_valid = 1'b0;
  logic       in_op = shs_pkg::OP_APPEND;
  logic [7:0] in_byte = 8'h00;
  logic       out_ready = 1'b0;

  shs_in_if  in_ch ();
  shs_out_if out_ch ();

  assign in_ch.valid     = in_valid;
  assign in_ch.op        = in_op;
  assign in_ch.data_byte = in_byte;
  assign out_ch.ready    = out_ready;

  sha256_stream_hasher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Hash state mirrored by the testbench.
  logic [31:0]  hash_chain [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  msg_len;
  int unsigned  block_fill;

  shs_pkg::item_t cmd_q [$];
  digest_word_t   digest_q [$];
  int unsigned  cmd_total = 0;
  int unsigned  sent_cnt = 0;
  int unsigned  fail_cnt = 0;
  int unsigned  in_gap = 0;
  int unsigned  out_stall = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Hold both sides busy in some stretches and at the end of the run.
  function automatic bit quiet_stretch();
    return ((sent_cnt % 128) < 32) || (sent_cnt + 48 >= cmd_total);
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_chain[i] = SHA_H0[i];
    msg_len    = '0;
    block_fill = 0;
  endtask

  // Fold the full block into the chaining value.
  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endtask

  task automatic push_block_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      sha_compress();
      block_fill = 0;
    end
  endtask

  // Apply one accepted command; a finish queues the eight digest words.
  task automatic sha_absorb(input logic op, input logic [7:0] b);
    logic [63:0] bit_len;
    if (op == shs_pkg::OP_APPEND) begin
      push_block_byte(b);
      msg_len = msg_len + 61'd1;
    end else begin
      bit_len = {msg_len, 3'b000};
      push_block_byte(shs_pkg::PAD_BYTE);
      while (block_fill != shs_pkg::LEN_OFFSET) push_block_byte(8'h00);
      for (int k = 0; k < 8; k++) push_block_byte(bit_len[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++)
        digest_q.push_back('{word: hash_chain[k], idx: 3'(k),
                             is_last: (3'(k) == shs_pkg::WORD_LAST)});
      restart_hash();
    end
  endtask

  task automatic queue_cmd(input logic op, input logic [7:0] b);
    shs_pkg::item_t it;
    it.op        = op;
    it.data_byte = b;
    cmd_q.push_back(it);
  endtask

  // Drive commands from the pending queue, with random idle bursts.
  always @(posedge clk) begin
    shs_pkg::item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ch.ready) begin
        sha_absorb(in_op, in_byte);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet_stretch() && $urandom_range(0, 5) == 0) begin
          in_gap   <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          it = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= it.op;
          in_byte  <= it.data_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each digest word transfer and stall the output at random.
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_ch.valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h (index %0d)", out_ch.digest_word,
                 out_ch.word_index);
          fail_cnt++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_ch.digest_word !== exp_w.word) begin
            $error("digest_word: expected %h, got %h", exp_w.word, out_ch.digest_word);
            fail_cnt++;
          end
          if (out_ch.word_index !== exp_w.idx) begin
            $error("word_index: expected %0d, got %0d", exp_w.idx, out_ch.word_index);
            fail_cnt++;
          end
          if (out_ch.last_word !== exp_w.is_last) begin
            $error("last_word: expected %b, got %b", exp_w.is_last, out_ch.last_word);
            fail_cnt++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (!quiet_stretch() && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Build the command list, run it and report.
  initial begin
    int unsigned msg_bytes;
    int unsigned fill_mode;
    int unsigned pick;
    logic [7:0]  b;

    restart_hash();

    // Empty message, with the ignored data byte set.
    queue_cmd(shs_pkg::OP_FINISH, 8'hFF);
    // Known vector "abc".
    queue_cmd(shs_pkg::OP_APPEND, 8'h61);
    queue_cmd(shs_pkg::OP_APPEND, 8'h62);
    queue_cmd(shs_pkg::OP_APPEND, 8'h63);
    queue_cmd(shs_pkg::OP_FINISH, 8'h00);
    // Byte extremes, then a finish with a nonzero ignored byte.
    queue_cmd(shs_pkg::OP_APPEND, 8'h00);
    queue_cmd(shs_pkg::OP_APPEND, 8'hFF);
    queue_cmd(shs_pkg::OP_APPEND, 8'h80);
    queue_cmd(shs_pkg::OP_APPEND, 8'h7F);
    queue_cmd(shs_pkg::OP_FINISH, 8'h5A);
    // Back-to-back finishes: state must be back at reset after each.
    queue_cmd(shs_pkg::OP_FINISH, 8'hA5);
    queue_cmd(shs_pkg::OP_APPEND, 8'h01);
    queue_cmd(shs_pkg::OP_FINISH, 8'h00);

    // Random messages, weighted toward the padding boundaries.
    while (cmd_q.size() < MsgTarget) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          msg_bytes = $urandom_range(0, 3);
        end
        1, 2, 3: begin
          msg_bytes = $urandom_range(54, 57);
        end
        4: begin
          msg_bytes = $urandom_range(62, 65);
        end
        5: begin
          msg_bytes = $urandom_range(118, 121);
        end
        default: begin
          msg_bytes = $urandom_range(0, 50);
        end
      endcase
      // Trim the last message so the run ends on the item budget.
      if (cmd_q.size() + msg_bytes + 1 > MsgTarget) begin
        msg_bytes = MsgTarget - cmd_q.size() - 1;
      end
      fill_mode = $urandom_range(0, 7);
      for (int i = 0; i < msg_bytes; i++) begin
        if (fill_mode == 0) b = 8'h00;
        else if (fill_mode == 1) b = 8'hFF;
        else b = 8'($urandom_range(0, 255));
        queue_cmd(shs_pkg::OP_APPEND, b);
      end
      queue_cmd(shs_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
    end
    cmd_total = cmd_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every command sent, every digest word seen, then watch for strays.
    while (sent_cnt != cmd_total || digest_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
